FILE: hw/rtl/lepi_pkg.sv
// ----------------------------------------------------------------------------
// lepi_pkg
// Shared types, constants and the step program for the paired Lorenz
// Euler integrator.
// ----------------------------------------------------------------------------
package lepi_pkg;

   // number format
   localparam int WORD_BITS = 48;
   localparam int FRAC_BITS = 32;
   localparam int COEF_BITS = WORD_BITS - 1;
   localparam int DEC_BITS  = 16;

   // shared multiplier: operands split into two halves
   localparam int HALF_BITS = (WORD_BITS + 1) / 2;
   localparam int MAG_BITS  = 2 * HALF_BITS;
   localparam int PROD_BITS = 2 * HALF_BITS;
   localparam int ACC_BITS  = 4 * HALF_BITS;
   localparam int QUOT_BITS = ACC_BITS - FRAC_BITS;

   // program sequencer
   localparam int STEP_BITS = 4;

   // register port
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int REG_IDX_BITS  = 3;
   localparam int REG_IDX_LSB   = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_SIGMA     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_RHO       = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_BETA      = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_TIME_STEP = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_DECIMATE  = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_Y_SHIFT   = 3'd5;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // reset values
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
   localparam logic [COEF_BITS-1:0] SIGMA_RESET = COEF_BITS'(ONE_Q * 64'd10);
   localparam logic [COEF_BITS-1:0] RHO_RESET   = COEF_BITS'(ONE_Q * 64'd28);
   localparam logic [COEF_BITS-1:0] BETA_RESET  = COEF_BITS'((ONE_Q * 64'd8) / 64'd3);
   localparam logic [COEF_BITS-1:0] DT_RESET    =
      COEF_BITS'((ONE_Q + 64'd50000) / 64'd100000);
   localparam logic [DEC_BITS-1:0]  DEC_RESET   = 16'd10;
   localparam logic [WORD_BITS-1:0] XY_RESET    = WORD_BITS'(ONE_Q);
   localparam logic [WORD_BITS-1:0] Z_RESET     = WORD_BITS'(ONE_Q * 64'd10);

   typedef struct packed {
      logic                        command;
      logic signed [WORD_BITS-1:0] init_a_x;
      logic signed [WORD_BITS-1:0] init_a_y;
      logic signed [WORD_BITS-1:0] init_a_z;
      logic signed [WORD_BITS-1:0] init_b_x;
      logic signed [WORD_BITS-1:0] init_b_y;
      logic signed [WORD_BITS-1:0] init_b_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_a_x;
      logic signed [WORD_BITS-1:0] out_a_y;
      logic signed [WORD_BITS-1:0] out_a_z;
      logic signed [WORD_BITS-1:0] out_b_x;
      logic signed [WORD_BITS-1:0] out_b_y;
      logic signed [WORD_BITS-1:0] out_b_z;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } op_type;

   typedef enum logic [3:0] {
      SRC_X,
      SRC_Y,
      SRC_Z,
      SRC_T0,
      SRC_T1,
      SRC_T2,
      SRC_T3,
      SRC_SIGMA,
      SRC_RHO,
      SRC_BETA,
      SRC_DT,
      SRC_SHIFT
   } src_type;

   typedef enum logic [2:0] {
      DST_T0,
      DST_T1,
      DST_T2,
      DST_T3,
      DST_X,
      DST_Y,
      DST_Z
   } dst_type;

   typedef struct packed {
      op_type  op;
      src_type src_a;
      src_type src_b;
      dst_type dst;
   } uop_type;

   // one Euler step of one trajectory, run once per trajectory
   function automatic uop_type prog_step(input logic [STEP_BITS-1:0] step);
      uop_type u;
      case (step)
         4'd0:    u = '{OP_SUB, SRC_Y,     SRC_SHIFT, DST_T0};  // shifted y
         4'd1:    u = '{OP_SUB, SRC_T0,    SRC_X,     DST_T1};
         4'd2:    u = '{OP_MUL, SRC_SIGMA, SRC_T1,    DST_T1};  // dx
         4'd3:    u = '{OP_MUL, SRC_RHO,   SRC_X,     DST_T2};
         4'd4:    u = '{OP_SUB, SRC_T2,    SRC_T0,    DST_T2};
         4'd5:    u = '{OP_MUL, SRC_X,     SRC_Z,     DST_T3};
         4'd6:    u = '{OP_SUB, SRC_T2,    SRC_T3,    DST_T2};  // dy
         4'd7:    u = '{OP_MUL, SRC_X,     SRC_T0,    DST_T3};
         4'd8:    u = '{OP_MUL, SRC_BETA,  SRC_Z,     DST_T0};
         4'd9:    u = '{OP_SUB, SRC_T3,    SRC_T0,    DST_T3};  // dz
         4'd10:   u = '{OP_MUL, SRC_T1,    SRC_DT,    DST_T1};
         4'd11:   u = '{OP_ADD, SRC_T1,    SRC_X,     DST_X};
         4'd12:   u = '{OP_MUL, SRC_T2,    SRC_DT,    DST_T2};
         4'd13:   u = '{OP_ADD, SRC_T2,    SRC_Y,     DST_Y};
         4'd14:   u = '{OP_MUL, SRC_T3,    SRC_DT,    DST_T3};
         4'd15:   u = '{OP_ADD, SRC_T3,    SRC_Z,     DST_Z};
         default: u = '{OP_ADD, SRC_T0,    SRC_T0,    DST_T0};
      endcase
      return u;
   endfunction

endpackage

FILE: hw/rtl/lorenz_euler_pair_integrator_top.sv
// ----------------------------------------------------------------------------
// lorenz_euler_pair_integrator_top
// Two Lorenz trajectories advanced by forward Euler steps in signed Q16.32.
//
// Request channel (req_valid / req_stall / req_data): a load request sets
// both initial states and clears the tick count, with no response. A tick
// request advances both trajectories by one step; every decimation-th tick
// produces one response holding all six coordinates.
// A tick runs a 16-entry step program twice (once per trajectory) on one
// shared 24x24 multiplier and one saturating adder: a multiply steps
// through operand latch, four partial products, accumulate, and round and
// saturate; the tick ends in a closing state that registers any response.
// req_stall is high while a tick runs, so no new request is taken until the
// previous tick has finished.
// Response channel (rsp_valid / rsp_stall / rsp_data): a response stays
// registered while the receiver stalls; the next request is still taken,
// and a tick that needs to emit waits in its closing cycle until the
// output register is free.
// Register port: APB style, 64-bit data, register i at byte address 8*i.
// Synchronous reset restores default coefficients, initial states
// (1, 1, 10) and a zero tick count.
// ----------------------------------------------------------------------------
module lorenz_euler_pair_integrator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lepi_pkg::req_type                    req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lepi_pkg::rsp_type                    rsp_data,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lepi_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lepi_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lepi_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int W = lepi_pkg::WORD_BITS;
   localparam int H = lepi_pkg::HALF_BITS;

   // multiply sequence counter phases
   localparam logic [2:0] MUL_LATCH = 3'd0;
   localparam logic [2:0] MUL_ACC0  = 3'd2;
   localparam logic [2:0] MUL_ACC3  = 3'd5;
   localparam logic [2:0] MUL_LAST  = 3'd6;

   // configuration registers
   logic [lepi_pkg::COEF_BITS-1:0] sigma_ff, rho_ff, beta_ff, dt_ff;
   logic [lepi_pkg::DEC_BITS-1:0]  decim_ff;
   logic signed [W-1:0]            y_shift_ff;

   // sequencer and trajectory state
   lepi_pkg::state_type             state_ff, state_in;
   logic [lepi_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                            traj_ff, traj_in;
   logic [2:0]                      mul_cnt_ff, mul_cnt_in;
   logic [lepi_pkg::DEC_BITS-1:0]   tick_ff, tick_in;
   logic signed [W-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [W-1:0] ax_in, ay_in, az_in, bx_in, by_in, bz_in;
   logic signed [W-1:0] t0_ff, t1_ff, t2_ff, t3_ff;
   logic signed [W-1:0] t0_in, t1_in, t2_in, t3_in;

   // multiplier datapath
   logic [lepi_pkg::MAG_BITS-1:0]  ma_ff, mb_ff, ma_in, mb_in;
   logic                           neg_ff, neg_in;
   logic [lepi_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [1:0]                     pidx_ff, pidx_in;
   logic [lepi_pkg::ACC_BITS-1:0]  acc_ff, acc_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   lepi_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // combinational datapath
   lepi_pkg::uop_type   uop;
   logic signed [W-1:0] cur_x, cur_y, cur_z, cur_shift;
   logic signed [W-1:0] op_a, op_b;
   logic [W-1:0]        abs_a, abs_b;
   logic signed [W:0]   sum_wide;
   logic signed [W-1:0] addsub_res;
   logic [1:0]          part_idx;
   logic [H-1:0]        part_a, part_b;
   logic [lepi_pkg::ACC_BITS-1:0]  prod_ext, prod_shifted;
   logic [lepi_pkg::QUOT_BITS-1:0] quot, quot_inc, quot_lim, quot_sat;
   logic                rem_nz;
   logic [W-1:0]        mag_w;
   logic signed [W-1:0] mul_res;
   logic                wb_en;
   logic signed [W-1:0] wb_val;
   logic                step_done;
   logic [lepi_pkg::DEC_BITS-1:0] tick_next;
   logic                req_take, csr_write;

   assign req_stall  = (state_ff != lepi_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff   <= lepi_pkg::SIGMA_RESET;
         rho_ff     <= lepi_pkg::RHO_RESET;
         beta_ff    <= lepi_pkg::BETA_RESET;
         dt_ff      <= lepi_pkg::DT_RESET;
         decim_ff   <= lepi_pkg::DEC_RESET;
         y_shift_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[lepi_pkg::REG_IDX_LSB +: lepi_pkg::REG_IDX_BITS])
            lepi_pkg::REG_SIGMA:     sigma_ff   <= csr_pwdata[lepi_pkg::COEF_BITS-1:0];
            lepi_pkg::REG_RHO:       rho_ff     <= csr_pwdata[lepi_pkg::COEF_BITS-1:0];
            lepi_pkg::REG_BETA:      beta_ff    <= csr_pwdata[lepi_pkg::COEF_BITS-1:0];
            lepi_pkg::REG_TIME_STEP: dt_ff      <= csr_pwdata[lepi_pkg::COEF_BITS-1:0];
            lepi_pkg::REG_DECIMATE:  decim_ff   <= csr_pwdata[lepi_pkg::DEC_BITS-1:0];
            lepi_pkg::REG_Y_SHIFT:   y_shift_ff <= $signed(csr_pwdata[W-1:0]);
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[lepi_pkg::REG_IDX_LSB +: lepi_pkg::REG_IDX_BITS])
         lepi_pkg::REG_SIGMA:     csr_prdata = lepi_pkg::CSR_DATA_BITS'(sigma_ff);
         lepi_pkg::REG_RHO:       csr_prdata = lepi_pkg::CSR_DATA_BITS'(rho_ff);
         lepi_pkg::REG_BETA:      csr_prdata = lepi_pkg::CSR_DATA_BITS'(beta_ff);
         lepi_pkg::REG_TIME_STEP: csr_prdata = lepi_pkg::CSR_DATA_BITS'(dt_ff);
         lepi_pkg::REG_DECIMATE:  csr_prdata = lepi_pkg::CSR_DATA_BITS'(decim_ff);
         lepi_pkg::REG_Y_SHIFT:
            csr_prdata = lepi_pkg::CSR_DATA_BITS'(unsigned'(y_shift_ff));
         default:                 csr_prdata = '0;
      endcase
   end

   // current micro-op and the trajectory it works on
   always_comb begin
      uop       = lepi_pkg::prog_step(step_ff);
      cur_x     = traj_ff ? bx_ff : ax_ff;
      cur_y     = traj_ff ? by_ff : ay_ff;
      cur_z     = traj_ff ? bz_ff : az_ff;
      cur_shift = traj_ff ? y_shift_ff : '0;
   end

   // operand a select
   always_comb begin
      case (uop.src_a)
         lepi_pkg::SRC_X:     op_a = cur_x;
         lepi_pkg::SRC_Y:     op_a = cur_y;
         lepi_pkg::SRC_Z:     op_a = cur_z;
         lepi_pkg::SRC_T0:    op_a = t0_ff;
         lepi_pkg::SRC_T1:    op_a = t1_ff;
         lepi_pkg::SRC_T2:    op_a = t2_ff;
         lepi_pkg::SRC_T3:    op_a = t3_ff;
         lepi_pkg::SRC_SIGMA: op_a = $signed({1'b0, sigma_ff});
         lepi_pkg::SRC_RHO:   op_a = $signed({1'b0, rho_ff});
         lepi_pkg::SRC_BETA:  op_a = $signed({1'b0, beta_ff});
         lepi_pkg::SRC_DT:    op_a = $signed({1'b0, dt_ff});
         lepi_pkg::SRC_SHIFT: op_a = cur_shift;
         default:             op_a = '0;
      endcase
   end

   // operand b select
   always_comb begin
      case (uop.src_b)
         lepi_pkg::SRC_X:     op_b = cur_x;
         lepi_pkg::SRC_Y:     op_b = cur_y;
         lepi_pkg::SRC_Z:     op_b = cur_z;
         lepi_pkg::SRC_T0:    op_b = t0_ff;
         lepi_pkg::SRC_T1:    op_b = t1_ff;
         lepi_pkg::SRC_T2:    op_b = t2_ff;
         lepi_pkg::SRC_T3:    op_b = t3_ff;
         lepi_pkg::SRC_SIGMA: op_b = $signed({1'b0, sigma_ff});
         lepi_pkg::SRC_RHO:   op_b = $signed({1'b0, rho_ff});
         lepi_pkg::SRC_BETA:  op_b = $signed({1'b0, beta_ff});
         lepi_pkg::SRC_DT:    op_b = $signed({1'b0, dt_ff});
         lepi_pkg::SRC_SHIFT: op_b = cur_shift;
         default:             op_b = '0;
      endcase
   end

   // saturating add / subtract
   always_comb begin
      if (uop.op == lepi_pkg::OP_SUB) begin
         sum_wide = {op_a[W-1], op_a} - {op_b[W-1], op_b};
      end else begin
         sum_wide = {op_a[W-1], op_a} + {op_b[W-1], op_b};
      end
      if (sum_wide[W] != sum_wide[W-1]) begin
         addsub_res = sum_wide[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         addsub_res = sum_wide[W-1:0];
      end
   end

   // operand magnitudes for the multiplier
   always_comb begin
      abs_a = op_a[W-1] ? (~unsigned'(op_a) + 1'b1) : unsigned'(op_a);
      abs_b = op_b[W-1] ? (~unsigned'(op_b) + 1'b1) : unsigned'(op_b);
   end

   // partial product select and shift into place
   always_comb begin
      part_idx = 2'(mul_cnt_ff - 3'd1);
      part_a   = part_idx[1] ? ma_ff[2*H-1:H] : ma_ff[H-1:0];
      part_b   = part_idx[0] ? mb_ff[2*H-1:H] : mb_ff[H-1:0];
      prod_ext = lepi_pkg::ACC_BITS'(prod_ff);
      case (pidx_ff)
         2'd0:    prod_shifted = prod_ext;
         2'd1:    prod_shifted = prod_ext << H;
         2'd2:    prod_shifted = prod_ext << H;
         2'd3:    prod_shifted = prod_ext << (2 * H);
         default: prod_shifted = prod_ext;
      endcase
   end

   // drop fraction bits rounding toward minus infinity, then saturate
   always_comb begin
      quot     = acc_ff[lepi_pkg::ACC_BITS-1:lepi_pkg::FRAC_BITS];
      rem_nz   = |acc_ff[lepi_pkg::FRAC_BITS-1:0];
      quot_inc = quot + lepi_pkg::QUOT_BITS'(neg_ff && rem_nz);
      quot_lim = (lepi_pkg::QUOT_BITS'(1) << (W - 1)) - lepi_pkg::QUOT_BITS'(!neg_ff);
      quot_sat = (quot_inc > quot_lim) ? quot_lim : quot_inc;
      mag_w    = quot_sat[W-1:0];
      mul_res  = neg_ff ? $signed(~mag_w + 1'b1) : $signed(mag_w);
   end

   // sequencer, next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      traj_in      = traj_ff;
      mul_cnt_in   = mul_cnt_ff;
      tick_in      = tick_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  az_in = az_ff;
      bx_in = bx_ff;  by_in = by_ff;  bz_in = bz_ff;
      t0_in = t0_ff;  t1_in = t1_ff;  t2_in = t2_ff;  t3_in = t3_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      neg_in       = neg_ff;
      prod_in      = part_a * part_b;
      pidx_in      = part_idx;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wb_en        = 1'b0;
      wb_val       = addsub_res;
      step_done    = 1'b0;
      tick_next    = tick_ff + 1'b1;

      // response taken by the receiver
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lepi_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_data.command == lepi_pkg::CMD_LOAD) begin
                  ax_in   = req_data.init_a_x;
                  ay_in   = req_data.init_a_y;
                  az_in   = req_data.init_a_z;
                  bx_in   = req_data.init_b_x;
                  by_in   = req_data.init_b_y;
                  bz_in   = req_data.init_b_z;
                  tick_in = '0;
               end else begin
                  state_in   = lepi_pkg::ST_RUN;
                  step_in    = '0;
                  traj_in    = 1'b0;
                  mul_cnt_in = MUL_LATCH;
               end
            end
         end

         lepi_pkg::ST_RUN: begin
            if (uop.op == lepi_pkg::OP_MUL) begin
               mul_cnt_in = mul_cnt_ff + 3'd1;
               if (mul_cnt_ff == MUL_LATCH) begin
                  ma_in  = lepi_pkg::MAG_BITS'(abs_a);
                  mb_in  = lepi_pkg::MAG_BITS'(abs_b);
                  neg_in = op_a[W-1] ^ op_b[W-1];
                  acc_in = '0;
               end
               if (mul_cnt_ff >= MUL_ACC0 && mul_cnt_ff <= MUL_ACC3) begin
                  acc_in = acc_ff + prod_shifted;
               end
               if (mul_cnt_ff == MUL_LAST) begin
                  wb_en      = 1'b1;
                  wb_val     = mul_res;
                  step_done  = 1'b1;
                  mul_cnt_in = MUL_LATCH;
               end
            end else begin
               wb_en     = 1'b1;
               step_done = 1'b1;
            end

            // program advance; second pass runs the shifted trajectory
            if (step_done) begin
               step_in = step_ff + 1'b1;
               if (&step_ff) begin
                  if (traj_ff) begin
                     state_in = lepi_pkg::ST_FINISH;
                  end
                  traj_in = 1'b1;
               end
            end
         end

         lepi_pkg::ST_FINISH: begin
            if (tick_next == decim_ff) begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.out_a_x = ax_ff;
                  rsp_data_in.out_a_y = ay_ff;
                  rsp_data_in.out_a_z = az_ff;
                  rsp_data_in.out_b_x = bx_ff;
                  rsp_data_in.out_b_y = by_ff;
                  rsp_data_in.out_b_z = bz_ff;
                  tick_in             = '0;
                  state_in            = lepi_pkg::ST_IDLE;
               end
            end else begin
               tick_in  = tick_next;
               state_in = lepi_pkg::ST_IDLE;
            end
         end

         default: state_in = lepi_pkg::ST_IDLE;
      endcase

      // write back the micro-op result
      if (wb_en) begin
         case (uop.dst)
            lepi_pkg::DST_T0: t0_in = wb_val;
            lepi_pkg::DST_T1: t1_in = wb_val;
            lepi_pkg::DST_T2: t2_in = wb_val;
            lepi_pkg::DST_T3: t3_in = wb_val;
            lepi_pkg::DST_X: begin
               if (traj_ff) bx_in = wb_val; else ax_in = wb_val;
            end
            lepi_pkg::DST_Y: begin
               if (traj_ff) by_in = wb_val; else ay_in = wb_val;
            end
            lepi_pkg::DST_Z: begin
               if (traj_ff) bz_in = wb_val; else az_in = wb_val;
            end
            default: ;
         endcase
      end
   end

   // control and trajectory state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lepi_pkg::ST_IDLE;
         step_ff      <= '0;
         traj_ff      <= 1'b0;
         mul_cnt_ff   <= MUL_LATCH;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= lepi_pkg::XY_RESET;
         ay_ff        <= lepi_pkg::XY_RESET;
         az_ff        <= lepi_pkg::Z_RESET;
         bx_ff        <= lepi_pkg::XY_RESET;
         by_ff        <= lepi_pkg::XY_RESET;
         bz_ff        <= lepi_pkg::Z_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         traj_ff      <= traj_in;
         mul_cnt_ff   <= mul_cnt_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         az_ff        <= az_in;
         bx_ff        <= bx_in;
         by_ff        <= by_in;
         bz_ff        <= bz_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      pidx_ff     <= pidx_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
